// ===== sv/bkl_pkg.sv =====
// ----------------------------------------------------------------------------
// bkl_pkg
// shared types and codes of the bounded keyed list unit
// ----------------------------------------------------------------------------
package bkl_pkg;

  localparam int unsigned CAPACITY = 16;

  typedef enum logic [1:0] {
    CMD_INS_FRONT = 2'd0,
    CMD_INS_BACK  = 2'd1,
    CMD_REMOVE    = 2'd2,
    CMD_SEARCH    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] payload;
  } rec_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  position;
    logic [31:0] payload;
    logic [4:0]  total;
    logic        empty;
  } result_t;

endpackage

// ===== sv/bkl_mem.sv =====
// ----------------------------------------------------------------------------
// bkl_mem
// record store, one write and one registered read port
// ----------------------------------------------------------------------------
module bkl_mem #(
  parameter int unsigned Depth = bkl_pkg::CAPACITY,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  bkl_pkg::rec_t    wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output bkl_pkg::rec_t    rdata_o
);

  bkl_pkg::rec_t mem [Depth];
  bkl_pkg::rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bkl_seq.sv =====
// ----------------------------------------------------------------------------
// bkl_seq
// command sequencer: scans, shifts and writes back the record store
// ----------------------------------------------------------------------------
module bkl_seq #(
  parameter int unsigned Capacity = bkl_pkg::CAPACITY,
  parameter int unsigned AddrW    = 4,
  parameter int unsigned CntW     = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bkl_pkg::cmd_e     cmd_i,
  input  logic [15:0]       key_id_i,
  input  logic [31:0]       item_payload_i,
  output logic              mem_we_o,
  output logic [AddrW-1:0]  mem_waddr_o,
  output bkl_pkg::rec_t     mem_wdata_o,
  output logic              mem_re_o,
  output logic [AddrW-1:0]  mem_raddr_o,
  input  bkl_pkg::rec_t     mem_rdata_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output bkl_pkg::result_t  res_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_DOWN = 6'b000100,
    S_UP   = 6'b001000,
    S_HEAD = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   ptr_q, ptr_d;
  logic [CntW-1:0]   pidx_q, pidx_d;
  logic              pend_q, pend_d;
  logic              more_q, more_d;
  bkl_pkg::cmd_e     cmd_q, cmd_d;
  logic [15:0]       key_q, key_d;
  logic [31:0]       pay_q, pay_d;
  bkl_pkg::status_e  stat_q, stat_d;
  logic [3:0]        pos_q, pos_d;
  logic [31:0]       fpay_q, fpay_d;

  logic              full;
  logic              hit;
  logic [CntW-1:0]   pnext;
  logic [CntW-1:0]   pprev;

  assign full  = (cnt_q == CntW'(Capacity));
  assign hit   = pend_q && (mem_rdata_i.id == key_q);
  assign pnext = pidx_q + CntW'(1);
  assign pprev = pidx_q - CntW'(1);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    pidx_d      = pidx_q;
    pend_d      = 1'b0;
    more_d      = more_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    pay_d       = pay_q;
    stat_d      = stat_q;
    pos_d       = pos_q;
    fpay_d      = fpay_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q[AddrW-1:0];
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = mem_rdata_i;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = cmd_i;
          key_d  = key_id_i;
          pay_d  = item_payload_i;
          stat_d = bkl_pkg::ST_OK;
          pos_d  = '0;
          fpay_d = '0;
          ptr_d  = '0;
          more_d = 1'b1;
          case (cmd_i)
            bkl_pkg::CMD_INS_FRONT: begin
              if (full) begin
                stat_d  = bkl_pkg::ST_FULL;
                state_d = S_DONE;
              end else if (cnt_q == '0) begin
                state_d = S_HEAD;
              end else begin
                ptr_d   = cnt_q - CntW'(1);
                state_d = S_UP;
              end
            end
            bkl_pkg::CMD_INS_BACK: begin
              if (full) begin
                stat_d = bkl_pkg::ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = cnt_q[AddrW-1:0];
                mem_wdata_o = '{id: key_id_i, payload: item_payload_i};
                cnt_d       = cnt_q + CntW'(1);
              end
              state_d = S_DONE;
            end
            bkl_pkg::CMD_REMOVE: begin
              if (cnt_q == '0) begin
                stat_d  = bkl_pkg::ST_EMPTY;
                state_d = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            bkl_pkg::CMD_SEARCH: begin
              if (cnt_q == '0) begin
                stat_d  = bkl_pkg::ST_NOT_FOUND;
                state_d = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (ptr_q < cnt_q) begin
          mem_re_o = 1'b1;
          pidx_d   = ptr_q;
          pend_d   = 1'b1;
          ptr_d    = ptr_q + CntW'(1);
        end
        if (hit) begin
          fpay_d = mem_rdata_i.payload;
          pend_d = 1'b0;
          if (cmd_q == bkl_pkg::CMD_SEARCH) begin
            pos_d   = 4'(pidx_q);
            state_d = S_DONE;
          end else if (pnext < cnt_q) begin
            ptr_d   = pnext;
            state_d = S_DOWN;
          end else begin
            cnt_d   = cnt_q - CntW'(1);
            state_d = S_DONE;
          end
        end else if (pend_q && (ptr_q >= cnt_q)) begin
          stat_d  = bkl_pkg::ST_NOT_FOUND;
          pend_d  = 1'b0;
          state_d = S_DONE;
        end
      end
      S_DOWN: begin
        if (ptr_q < cnt_q) begin
          mem_re_o = 1'b1;
          pidx_d   = ptr_q;
          pend_d   = 1'b1;
          ptr_d    = ptr_q + CntW'(1);
        end
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pprev[AddrW-1:0];
          mem_wdata_o = mem_rdata_i;
          if (ptr_q >= cnt_q) begin
            cnt_d   = cnt_q - CntW'(1);
            pend_d  = 1'b0;
            state_d = S_DONE;
          end
        end
      end
      S_UP: begin
        if (more_q) begin
          mem_re_o = 1'b1;
          pidx_d   = ptr_q;
          pend_d   = 1'b1;
          if (ptr_q == '0) begin
            more_d = 1'b0;
          end else begin
            ptr_d = ptr_q - CntW'(1);
          end
        end
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pnext[AddrW-1:0];
          mem_wdata_o = mem_rdata_i;
          if (!more_q) begin
            state_d = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = '0;
        mem_wdata_o = '{id: key_q, payload: pay_q};
        cnt_d       = cnt_q + CntW'(1);
        state_d     = S_DONE;
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      more_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      more_q  <= more_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    pidx_q <= pidx_d;
    cmd_q  <= cmd_d;
    key_q  <= key_d;
    pay_q  <= pay_d;
    stat_q <= stat_d;
    pos_q  <= pos_d;
    fpay_q <= fpay_d;
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign res_o.status   = stat_q;
  assign res_o.position = pos_q;
  assign res_o.payload  = fpay_q;
  assign res_o.total    = 5'(cnt_q);
  assign res_o.empty    = (cnt_q == '0);

endmodule

// ===== sv/bounded_keyed_list_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_keyed_list_unit
// ordered list of keyed records held in a single-port-read record store
// ----------------------------------------------------------------------------
//  channel  direction  handshake                word
//  in       input      in_valid_i / in_stall_o  cmd, key_id, item_payload
//  out      output     out_valid_o / out_stall_i status, position,
//                                               found_payload, entry_total,
//                                               is_empty
//
//  the single read port of the record store paces every scan and shift;
//  insert front shifts the list up before writing the head, remove shifts
//  the records after the hit down
//  reset clears the record count and control state, not the store; no clearing
//  pass, stale slots are never read
//  a result waits in the output register while the next word is accepted;
//  that word completes once the register is free
// ----------------------------------------------------------------------------
module bounded_keyed_list_unit #(
  parameter int unsigned CAPACITY = bkl_pkg::CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] key_id_i,
  input  logic [31:0] item_payload_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  position_o,
  output logic [31:0] found_payload_o,
  output logic [4:0]  entry_total_o,
  output logic        is_empty_o
);

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  bkl_pkg::rec_t     mem_wdata;
  logic              mem_re;
  logic [AddrW-1:0]  mem_raddr;
  bkl_pkg::rec_t     mem_rdata;

  logic              res_valid;
  logic              res_ready;
  bkl_pkg::result_t  res;

  logic              out_valid_q;
  bkl_pkg::result_t  out_q;

  bkl_mem #(
    .Depth (CAPACITY),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bkl_seq #(
    .Capacity (CAPACITY),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (bkl_pkg::cmd_e'(cmd_i)),
    .key_id_i       (key_id_i),
    .item_payload_i (item_payload_i),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign position_o      = out_q.position;
  assign found_payload_o = out_q.payload;
  assign entry_total_o   = out_q.total;
  assign is_empty_o      = out_q.empty;

  a_full_total : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == bkl_pkg::ST_FULL) |-> entry_total_o == 5'(CAPACITY))
    else $error("full status with a short list");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != bkl_pkg::ST_OK) |-> (position_o == '0) && (found_payload_o == '0))
    else $error("failed command returned data");

  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (CAPACITY < 32) |-> is_empty_o == (entry_total_o == '0))
    else $error("empty flag disagrees with count");

  a_busy_before_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result loaded while sequencer idle");

endmodule
